[rtl/core/tvalu_pkg.sv]
// Package for the tagged value ALU: tag and command codes, pipeline control struct.
// No dependencies.
`timescale 1ns / 1ps
package tvalu_pkg;
	localparam logic [2:0] TAG_NULL  = 3'd0;
	localparam logic [2:0] TAG_BOOL  = 3'd2;
	localparam logic [2:0] TAG_INT   = 3'd3;
	localparam logic [2:0] TAG_FLOAT = 3'd4;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_SUB    = 3'd1;
	localparam logic [2:0] CMD_MUL    = 3'd2;
	localparam logic [2:0] CMD_EQ     = 3'd3;
	localparam logic [2:0] CMD_NE     = 3'd4;
	localparam logic [2:0] CMD_TRUTHY = 3'd5;

	localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;

	// Decoded routing of one beat through the pipeline.
	typedef struct packed {
		logic       arith;    // add, sub or mul on two numbers
		logic       is_float; // arithmetic or compare in double
		logic       is_mul;
		logic       is_sub;
		logic       cmp_num;  // numeric compare
		logic       negate;   // ne
		logic       err;
		logic [2:0] fix_type; // result for non-numeric paths
		logic       fix_bit;
	} tvalu_ctl_t;
endpackage

[rtl/core/tagged_value_numeric_alu_top.sv]
// Tagged value ALU: int64 and double add, sub, mul, cross-type eq and ne, truthy.
// Depends on tvalu_pkg, tvalu_i2d and tvalu_fpu.
// done rises in the same cycle as the registered result appears; one beat per cycle.
// The int-to-double stages (2) and the three-stage double unit set the depth.
// busy is always low and results cannot be stalled; reset clears the valid bits only.
`timescale 1ns / 1ps
module tagged_value_numeric_alu_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic [2:0]         type_a,
	input  logic signed [63:0] value_a,
	input  logic [2:0]         type_b,
	input  logic signed [63:0] value_b,
	output logic               done,
	output logic [2:0]         result_type,
	output logic signed [63:0] result_value,
	output logic               type_error
);
	localparam int Depth = 6;

	tvalu_pkg::tvalu_ctl_t ctl;
	logic num_a, num_b, both_int;

	always_comb begin
		num_a = type_a == tvalu_pkg::TAG_INT || type_a == tvalu_pkg::TAG_FLOAT;
		num_b = type_b == tvalu_pkg::TAG_INT || type_b == tvalu_pkg::TAG_FLOAT;
		both_int = type_a == tvalu_pkg::TAG_INT && type_b == tvalu_pkg::TAG_INT;
		ctl = '0;
		ctl.err = 1'b1;
		ctl.fix_type = tvalu_pkg::TAG_NULL;
		ctl.is_float = ~both_int;
		ctl.is_mul = cmd == tvalu_pkg::CMD_MUL;
		ctl.is_sub = cmd == tvalu_pkg::CMD_SUB;
		ctl.negate = cmd == tvalu_pkg::CMD_NE;
		case (cmd)
			tvalu_pkg::CMD_ADD, tvalu_pkg::CMD_SUB, tvalu_pkg::CMD_MUL: begin
				if (num_a && num_b) begin
					ctl.arith = 1'b1;
					ctl.err = 1'b0;
				end
			end
			tvalu_pkg::CMD_EQ, tvalu_pkg::CMD_NE: begin
				ctl.fix_type = tvalu_pkg::TAG_BOOL;
				ctl.err = 1'b0;
				if (num_a && num_b) ctl.cmp_num = 1'b1;
				else if (type_a != type_b) ctl.fix_bit = ctl.negate;
				else if (type_a == tvalu_pkg::TAG_BOOL)
					ctl.fix_bit = (value_a[0] == value_b[0]) ^ ctl.negate;
				else if (type_a == tvalu_pkg::TAG_NULL) ctl.fix_bit = ~ctl.negate;
				else begin
					ctl.err = 1'b1;
					ctl.fix_type = tvalu_pkg::TAG_NULL;
				end
			end
			tvalu_pkg::CMD_TRUTHY: begin
				ctl.err = 1'b0;
				ctl.fix_type = tvalu_pkg::TAG_BOOL;
				if (type_a == tvalu_pkg::TAG_NULL) ctl.fix_bit = 1'b0;
				else if (type_a == tvalu_pkg::TAG_BOOL) ctl.fix_bit = value_a[0];
				else ctl.fix_bit = 1'b1;
			end
			default: ;
		endcase
	end

	// Integer results and int compare are formed in stage 1 and delayed.
	logic [63:0] iadd, isub;
	logic [63:0] ires_s1;
	logic        ieq_s1;
	logic [31:0] al_s1, ah_s1, bl_s1, bh_s1;
	assign iadd = value_a + value_b;
	assign isub = value_a - value_b;

	// 64-bit wrapping multiply as three 32x32 partial products over two stages.
	logic [63:0] ll_s2, lh_s2, hl_s2;
	logic [63:0] imul_s3;
	always_ff @(posedge clk) begin
		al_s1 <= value_a[31:0]; ah_s1 <= value_a[63:32];
		bl_s1 <= value_b[31:0]; bh_s1 <= value_b[63:32];
		ires_s1 <= ctl.is_sub ? isub : iadd;
		ieq_s1 <= value_a == value_b;
		ll_s2 <= {32'd0, al_s1} * {32'd0, bl_s1};
		lh_s2 <= {32'd0, al_s1} * {32'd0, bh_s1};
		hl_s2 <= {32'd0, ah_s1} * {32'd0, bl_s1};
		imul_s3 <= ll_s2 + {lh_s2[31:0] + hl_s2[31:0], 32'd0};
	end

	// Operands to double: floats pass through a matching delay.
	logic [63:0] da, db, fa_s1, fa_s2, fb_s1, fb_s2;
	logic        ia_s1, ia_s2, ib_s1, ib_s2;
	logic [63:0] ca, cb;
	tvalu_i2d u_i2d_a (.clk(clk), .ival(value_a), .dval(ca));
	tvalu_i2d u_i2d_b (.clk(clk), .ival(value_b), .dval(cb));
	always_ff @(posedge clk) begin
		fa_s1 <= value_a; fa_s2 <= fa_s1;
		fb_s1 <= value_b; fb_s2 <= fb_s1;
		ia_s1 <= type_a == tvalu_pkg::TAG_INT; ia_s2 <= ia_s1;
		ib_s1 <= type_b == tvalu_pkg::TAG_INT; ib_s2 <= ib_s1;
	end
	assign da = ia_s2 ? ca : fa_s2;
	assign db = ib_s2 ? cb : fb_s2;

	// Double equality at stage 3.
	logic deq_s3;
	logic da_nan, db_nan;
	always_comb begin
		da_nan = da[62:52] == 11'h7FF && da[51:0] != 52'd0;
		db_nan = db[62:52] == 11'h7FF && db[51:0] != 52'd0;
	end
	always_ff @(posedge clk) begin
		deq_s3 <= ~da_nan & ~db_nan & ((da == db) | (da[62:0] == 63'd0 && db[62:0] == 63'd0));
	end

	// Control and integer results travel alongside.
	tvalu_pkg::tvalu_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [63:0] ires_s2, ires_s3, ires_s4, ires_s5;
	logic        ieq_s2, ieq_s3;
	logic        eqb_s4, eqb_s5;
	logic [Depth-1:0] vld_q;

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl; ctl_s2 <= ctl_s1; ctl_s3 <= ctl_s2; ctl_s4 <= ctl_s3; ctl_s5 <= ctl_s4;
		ires_s2 <= ires_s1; ires_s3 <= ires_s2;
		ires_s4 <= ctl_s3.is_mul ? imul_s3 : ires_s3; ires_s5 <= ires_s4;
		ieq_s2 <= ieq_s1; ieq_s3 <= ieq_s2;
		eqb_s4 <= ctl_s3.is_float ? deq_s3 : ieq_s3; eqb_s5 <= eqb_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Depth-2:0], start & ~busy};
		end
	end

	logic [63:0] fres;
	tvalu_fpu u_fpu (
		.clk(clk), .is_mul(ctl_s2.is_mul), .is_sub(ctl_s2.is_sub),
		.x(da), .y(db), .r(fres)
	);

	// Stage 6 output register.
	always_ff @(posedge clk) begin
		if (ctl_s5.arith) begin
			result_type <= ctl_s5.is_float ? tvalu_pkg::TAG_FLOAT : tvalu_pkg::TAG_INT;
			result_value <= ctl_s5.is_float ? fres : ires_s5;
		end else if (ctl_s5.cmp_num) begin
			result_type <= tvalu_pkg::TAG_BOOL;
			result_value <= {63'd0, eqb_s5 ^ ctl_s5.negate};
		end else begin
			result_type <= ctl_s5.fix_type;
			result_value <= {63'd0, ctl_s5.fix_bit};
		end
		type_error <= ctl_s5.err;
	end

	assign done = vld_q[Depth-1];
	assign busy = 1'b0;
endmodule

[rtl/core/tvalu_i2d.sv]
// Signed 64-bit integer to IEEE double, round to nearest even, two register stages.
// Depends on no package; used by the ALU top level.
`timescale 1ns / 1ps
module tvalu_i2d (
	input  logic        clk,
	input  logic [63:0] ival,
	output logic [63:0] dval
);
	logic        sgn_s1;
	logic [63:0] mag_s1;
	logic [5:0]  lz;
	logic [63:0] norm;
	logic [52:0] mant;
	logic        rnd;
	logic [53:0] msum;
	logic [10:0] ex;

	always_ff @(posedge clk) begin
		sgn_s1 <= ival[63];
		mag_s1 <= ival[63] ? (~ival + 64'd1) : ival;
	end

	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (mag_s1[i]) lz = 6'(63 - i);
		end
		norm = mag_s1 << lz;
		mant = norm[63:11];
		rnd  = norm[10] & (norm[9:0] != 10'd0 | norm[11]);
		msum = {1'b0, mant} + {53'd0, rnd};
		ex   = 11'(1086 - {5'd0, lz}) + {10'd0, msum[53]};
	end

	always_ff @(posedge clk) begin
		if (mag_s1 == 64'd0) dval <= 64'd0;
		else dval <= {sgn_s1, ex, msum[53] ? msum[52:1] : msum[51:0]};
	end
endmodule

[rtl/core/tvalu_fpu.sv]
// Double add, subtract and multiply, round to nearest even, three register stages.
// Depends on no package; used by the ALU top level.
`timescale 1ns / 1ps
module tvalu_fpu (
	input  logic        clk,
	input  logic        is_mul,
	input  logic        is_sub,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic [63:0] r
);
	// Stage 1: unpack, align or multiply.
	logic        xs, ys, xn, yn, xi, yi, xz, yz;
	logic [10:0] xe, ye;
	logic [52:0] xm, ym;
	logic        big_x;
	logic [11:0] ediff;
	logic [52:0] lm, sm;
	logic [10:0] le;
	logic        ls, ss;

	logic        spec_s1;
	logic [63:0] spec_val_s1;
	logic        mul_s1, eff_sub_s1, sign_s1;
	logic signed [13:0] exp_s1;
	logic [55:0] lm_s1, sm_s1; // 53 bits + guard, round, sticky
	// Partial products of the 53-bit mantissas, split at bit 26.
	logic [51:0] pp_ll_s1;
	logic [52:0] pp_lh_s1, pp_hl_s1;
	logic [53:0] pp_hh_s1;

	always_comb begin
		xs = x[63]; ys = y[63] ^ (is_sub & ~is_mul);
		xe = x[62:52]; ye = y[62:52];
		xm = {xe != 11'd0, x[51:0]}; ym = {ye != 11'd0, y[51:0]};
		if (xe == 11'd0) xe = 11'd1;
		if (ye == 11'd0) ye = 11'd1;
		xn = (x[62:52] == 11'h7FF) & (x[51:0] != 52'd0);
		yn = (y[62:52] == 11'h7FF) & (y[51:0] != 52'd0);
		xi = (x[62:52] == 11'h7FF) & (x[51:0] == 52'd0);
		yi = (y[62:52] == 11'h7FF) & (y[51:0] == 52'd0);
		xz = x[62:0] == 63'd0; yz = y[62:0] == 63'd0;
		big_x = {xe, xm} >= {ye, ym};
		lm = big_x ? xm : ym; sm = big_x ? ym : xm;
		le = big_x ? xe : ye;
		ls = big_x ? xs : ys; ss = big_x ? ys : xs;
		ediff = big_x ? {1'b0, xe} - {1'b0, ye} : {1'b0, ye} - {1'b0, xe};
	end

	logic [55:0] sm_ext, sm_sh;
	logic        sticky_a;
	always_comb begin
		sm_ext = {sm, 3'b000};
		if (ediff > 12'd55) begin
			sm_sh = 56'd0;
			sticky_a = sm != 53'd0;
		end else begin
			sm_sh = sm_ext >> ediff[5:0];
			sticky_a = (sm_ext & ~({56{1'b1}} << ediff[5:0])) != 56'd0;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= is_mul;
		spec_s1 <= 1'b0;
		spec_val_s1 <= 64'd0;
		if (is_mul) begin
			sign_s1 <= xs ^ y[63];
			exp_s1 <= 14'(signed'({3'd0, xe})) + 14'(signed'({3'd0, ye})) - 14'sd1023;
			if (xn | yn | (xi & yz) | (yi & xz)) begin
				spec_s1 <= 1'b1; spec_val_s1 <= 64'h7FF8000000000000;
			end else if (xi | yi) begin
				spec_s1 <= 1'b1; spec_val_s1 <= {xs ^ y[63], 11'h7FF, 52'd0};
			end
		end else begin
			sign_s1 <= ls;
			exp_s1 <= 14'(signed'({3'd0, le}));
			if (xn | yn | (xi & yi & (xs != ys))) begin
				spec_s1 <= 1'b1; spec_val_s1 <= 64'h7FF8000000000000;
			end else if (xi | yi) begin
				spec_s1 <= 1'b1; spec_val_s1 <= {xi ? xs : ys, 11'h7FF, 52'd0};
			end else if (xz & yz) begin
				spec_s1 <= 1'b1; spec_val_s1 <= {xs & ys, 63'd0};
			end
		end
		eff_sub_s1 <= ls ^ ss;
		lm_s1 <= {lm, 3'b000};
		sm_s1 <= {sm_sh[55:1], sm_sh[0] | sticky_a};
		pp_ll_s1 <= {26'd0, xm[25:0]} * {26'd0, ym[25:0]};
		pp_lh_s1 <= {27'd0, xm[25:0]} * {26'd0, ym[52:26]};
		pp_hl_s1 <= {26'd0, xm[52:26]} * {27'd0, ym[25:0]};
		pp_hh_s1 <= {27'd0, xm[52:26]} * {27'd0, ym[52:26]};
	end

	// Stage 2: sum, or combine the partial products; normalize.
	logic [105:0] prod;
	logic [56:0] sum;
	logic [105:0] pre;
	logic [6:0]  lz;
	logic signed [13:0] en;
	logic [105:0] pn;
	logic [13:0] shamt;
	logic        lost;
	logic [105:0] nrm;
	logic        zero_sum;

	logic        spec_s2, sign_s2, zero_s2;
	logic [63:0] spec_val_s2;
	logic signed [13:0] exp_s2;
	logic [55:0] m_s2; // 53 + guard, round, sticky, leading one at bit 55

	always_comb begin
		prod = {pp_hh_s1, 52'd0} + {27'd0, pp_lh_s1, 26'd0} + {27'd0, pp_hl_s1, 26'd0}
			+ {54'd0, pp_ll_s1};
		sum = eff_sub_s1 ? {1'b0, lm_s1} - {1'b0, sm_s1} : {1'b0, lm_s1} + {1'b0, sm_s1};
		if (mul_s1) pre = prod;                    // leading one at bit 104 or 105
		else pre = {sum, 49'd0};                   // leading one near bit 104/105
		zero_sum = pre == 106'd0;
		lz = 7'd0;
		for (int i = 0; i < 106; i++) begin
			if (pre[i]) lz = 7'(105 - i);
		end
		// Value = pre * 2^(exp - 1023 - 104) in both paths after scaling.
		en = exp_s1 + 14'sd1 - 14'(signed'({7'd0, lz}));
		pn = pre << lz;
		shamt = 14'd0;
		lost = 1'b0;
		if (en < 14'sd1) begin
			// Subnormal: shift only as far as exponent allows, keeping the bits shifted out.
			shamt = 14'(14'sd1 - en);
			if (shamt > 14'd106) begin
				nrm = 106'd0;
				lost = pn != 106'd0;
			end else begin
				nrm = pn >> shamt[6:0];
				lost = (pn & ~({106{1'b1}} << shamt[6:0])) != 106'd0;
			end
			en = 14'sd0;
		end else nrm = pn;
	end

	always_ff @(posedge clk) begin
		spec_s2 <= spec_s1;
		spec_val_s2 <= spec_val_s1;
		sign_s2 <= (zero_sum & ~mul_s1) ? 1'b0 : sign_s1;
		zero_s2 <= zero_sum;
		exp_s2 <= en;
		m_s2 <= {nrm[105:51], (nrm[50:0] != 51'd0) | lost};
	end

	// Stage 3: round and pack.
	logic [53:0] rm;
	logic signed [13:0] ef;
	logic        up;
	always_comb begin
		up = m_s2[2] & (m_s2[1] | m_s2[0] | m_s2[3]);
		rm = {1'b0, m_s2[55:3]} + {53'd0, up};
		ef = exp_s2;
		if (rm[53]) begin
			rm = rm >> 1;
			ef = ef + 14'sd1;
		end else if (ef == 14'sd0 && rm[52]) ef = 14'sd1;
	end

	always_ff @(posedge clk) begin
		if (spec_s2) r <= spec_val_s2;
		else if (zero_s2) r <= {sign_s2, 63'd0};
		else if (ef >= 14'sd2047) r <= {sign_s2, 11'h7FF, 52'd0};
		else r <= {sign_s2, ef[10:0], rm[51:0]};
	end
endmodule
